>>> design/map_pkg.sv
// ----------------------------------------------------------------------------
// map_pkg
// Shared types and codes for the memory access profiler: transaction codes,
// access kinds, the input layout, the queued item and the packed result.
// ----------------------------------------------------------------------------
package map_pkg;

  localparam int IDX_W = 11;

  localparam logic [1:0] ACT_LOG   = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [1:0] KIND_DATA_READ  = 2'd1;
  localparam logic [1:0] KIND_DATA_WRITE = 2'd3;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  // input tdata layout, first field in the highest bits
  typedef struct packed {
    logic [3:0]  back_steps;
    logic [1:0]  requester;
    logic [1:0]  access_kind;
    logic [7:0]  data;
    logic [15:0] address;
    logic [31:0] cycle;
  } map_in_t;

  localparam int IN_DATA_W = $bits(map_in_t);

  typedef struct packed {
    logic [1:0]       op;
    logic [31:0]      cycle;
    logic [15:0]      address;
    logic [7:0]       data;
    logic [1:0]       access_kind;
    logic [1:0]       requester;
    logic [3:0]       back_steps;
    logic [IDX_W-1:0] idx;
  } map_item_t;

  // result tdata layout, first field in the highest bits
  typedef struct packed {
    logic [31:0] peak_count;
    logic        load_known;
    logic [15:0] load_address;
    logic [4:0]  values_held;
    logic [7:0]  past_value;
    logic [15:0] full_address;
    logic [1:0]  last_requester;
    logic [1:0]  last_kind;
    logic [31:0] last_cycle;
    logic [31:0] hit_count;
  } map_result_t;

  localparam int RES_W      = $bits(map_result_t);
  localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

endpackage

>>> design/map_front.sv
// ----------------------------------------------------------------------------
// map_front
// Accepts transactions, decodes the action and reduces the masked address to
// a table index (reciprocal multiply, then one correcting subtract).
// ----------------------------------------------------------------------------
module map_front #(
  parameter int TABLE_DEPTH = 2048
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                enable,
  input  logic                cfg_wr_en,
  input  logic [10:0]         cfg_wr_data,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [1:0]          in_tuser,
  input  logic [map_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                push_valid,
  input  logic                push_ready,
  output map_pkg::map_item_t  push_item
);
  import map_pkg::*;

  localparam int          RECIP_SHIFT = 22;
  localparam logic [21:0] RECIP       = 22'((1 << RECIP_SHIFT) / TABLE_DEPTH);
  localparam logic [27:0] DEPTH_C     = 28'(TABLE_DEPTH);

  logic [10:0]      mask_r;
  logic             stg_v_r;
  map_item_t        stg_item_r;
  logic [10:0]      stg_quo_r;

  map_in_t          in_f;
  logic [1:0]       op;
  logic [10:0]      masked;
  logic [32:0]      prod;
  logic             stg_adv;
  logic             take;
  logic [27:0]      qd;
  logic [27:0]      rem;

  assign in_f    = map_in_t'(in_tdata);
  assign masked  = in_f.address[10:0] & mask_r;
  assign prod    = 33'(masked) * 33'(RECIP);
  assign stg_adv = !stg_v_r || push_ready;
  assign in_tready = enable && stg_adv;
  assign take    = in_tvalid && in_tready;

  always_comb begin
    unique case (in_tuser)
      ACT_LOG:   op = ACT_LOG;
      ACT_CLEAR: op = ACT_CLEAR;
      default:   op = ACT_READ;
    endcase
  end

  // quotient estimate is low by at most one
  always_comb begin
    qd  = 28'(stg_quo_r) * DEPTH_C;
    rem = 28'(stg_item_r.idx) - qd;
    if (rem >= DEPTH_C) begin
      rem = rem - DEPTH_C;
    end
  end

  always_comb begin
    push_item     = stg_item_r;
    push_item.idx = rem[IDX_W-1:0];
  end
  assign push_valid = stg_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= 11'h7FF;
      stg_v_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mask_r <= cfg_wr_data;
      end
      if (stg_adv) begin
        stg_v_r <= take;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stg_item_r.op          <= op;
      stg_item_r.cycle       <= in_f.cycle;
      stg_item_r.address     <= in_f.address;
      stg_item_r.data        <= in_f.data;
      stg_item_r.access_kind <= in_f.access_kind;
      stg_item_r.requester   <= in_f.requester;
      stg_item_r.back_steps  <= in_f.back_steps;
      stg_item_r.idx         <= masked;
      stg_quo_r              <= prod[32:RECIP_SHIFT];
    end
  end

endmodule

>>> design/map_queue.sv
// ----------------------------------------------------------------------------
// map_queue
// Two-entry queue of decoded transactions between the front and the table
// sequencer.
// ----------------------------------------------------------------------------
module map_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  map_pkg::map_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output map_pkg::map_item_t pop_item
);
  import map_pkg::*;

  map_item_t  slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       do_push;
  logic       do_pop;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> design/map_back.sv
// ----------------------------------------------------------------------------
// map_back
// Table sequencer: read-modify-write of the entry, value ring update, peak
// tracking, linked load lookup, clearing sweeps and the result register.
// ----------------------------------------------------------------------------
module map_back #(
  parameter int TABLE_DEPTH = 2048,
  parameter int RING_LENGTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  output logic                 init_done,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  map_pkg::map_item_t   pop_item,
  output logic                 res_valid,
  input  logic                 res_ready,
  output map_pkg::map_result_t res
);
  import map_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = $clog2(RING_LENGTH);
  localparam int FW = $clog2(RING_LENGTH + 1);
  localparam int RW = RING_LENGTH * 8;

  localparam logic [AW-1:0] LAST_IDX  = AW'(TABLE_DEPTH - 1);
  localparam logic [PW-1:0] LAST_POS  = PW'(RING_LENGTH - 1);
  localparam logic [FW-1:0] FULL_FILL = FW'(RING_LENGTH);
  localparam logic [8:0]    RL9       = 9'(RING_LENGTH);
  localparam logic [9:0]    RL10      = 10'(RING_LENGTH);

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_CLR  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  typedef struct packed {
    logic [31:0]   count;
    logic [PW-1:0] pos;
    logic [FW-1:0] fill;
  } stat_t;

  typedef struct packed {
    logic [31:0]   cycle;
    logic [1:0]    kind;
    logic [1:0]    requester;
    logic          link_ok;
    logic [AW-1:0] link_idx;
  } info_t;

  stat_t         stat_mem [TABLE_DEPTH];
  info_t         info_mem [TABLE_DEPTH];
  logic [15:0]   addr_mem [TABLE_DEPTH];
  logic [RW-1:0] ring_mem [TABLE_DEPTH];

  stat_t         stat_rd_r;
  info_t         info_rd_r;
  logic [15:0]   addr_rd_r;
  logic [RW-1:0] ring_rd_r;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  map_item_t     cur_r;
  logic [31:0]   peak_r;
  logic          recent_ok_r;
  logic [AW-1:0] recent_idx_r;
  stat_t         nstat_r;
  info_t         ninfo_r;
  logic [15:0]   naddr_r;
  logic [7:0]    byte_r;
  logic          res_valid_r;
  map_result_t   res_r;

  logic [AW-1:0] e_cur;
  logic          log_op;
  stat_t         nstat;
  info_t         ninfo;
  logic [15:0]   naddr;
  logic [RW-1:0] nrow;
  logic [31:0]   npeak;
  logic [8:0]    back9;
  logic [9:0]    tpos;
  logic [7:0]    nbyte;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_stat;
  logic          wr_rest;
  logic [AW-1:0] wr_addr;
  logic          res_load;

  assign e_cur  = AW'(cur_r.idx);
  assign log_op = cur_r.op == ACT_LOG;
  assign init_done = state_r != ST_INIT;

  // entry update, valid in ST_UPD when the read data of the entry is back
  always_comb begin
    nstat = stat_rd_r;
    ninfo = info_rd_r;
    naddr = addr_rd_r;
    nrow  = ring_rd_r;
    npeak = peak_r;
    if (log_op) begin
      if (stat_rd_r.count != COUNT_MAX) begin
        nstat.count = stat_rd_r.count + 32'd1;
      end
      nstat.pos = (stat_rd_r.pos == LAST_POS) ? '0 : stat_rd_r.pos + PW'(1);
      if (stat_rd_r.fill != FULL_FILL) begin
        nstat.fill = stat_rd_r.fill + FW'(1);
      end
      ninfo.cycle     = cur_r.cycle;
      ninfo.kind      = cur_r.access_kind;
      ninfo.requester = cur_r.requester;
      ninfo.link_ok   = (cur_r.access_kind == KIND_DATA_WRITE) && recent_ok_r;
      ninfo.link_idx  = recent_idx_r;
      naddr           = cur_r.address;
      for (int i = 0; i < RING_LENGTH; i++) begin
        if (PW'(i) == stat_rd_r.pos) begin
          nrow[i*8 +: 8] = cur_r.data;
        end
      end
      if (nstat.count > peak_r) begin
        npeak = nstat.count;
      end
    end
  end

  // look-back slot, clamped to the ring length
  always_comb begin
    back9 = 9'(cur_r.back_steps);
    if (back9 >= RL9) begin
      back9 = RL9 - 9'd1;
    end
    tpos = 10'(nstat.pos) + RL10 - 10'(back9) - 10'd1;
    if (tpos >= RL10) begin
      tpos = tpos - RL10;
    end
    nbyte = '0;
    for (int i = 0; i < RING_LENGTH; i++) begin
      if (PW'(i) == tpos[PW-1:0]) begin
        nbyte = nrow[i*8 +: 8];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    pop_ready = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = e_cur;
    wr_stat   = 1'b0;
    wr_rest   = 1'b0;
    wr_addr   = ptr_r;
    res_load  = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        wr_stat = 1'b1;
        wr_rest = 1'b1;
        if (ptr_r == LAST_IDX) begin
          ptr_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          if (pop_item.op == ACT_CLEAR) begin
            state_nxt = ST_CLR;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = AW'(pop_item.idx);
            state_nxt = ST_UPD;
          end
        end
      end
      ST_CLR: begin
        wr_stat = 1'b1;
        if (ptr_r == LAST_IDX) begin
          ptr_nxt   = '0;
          state_nxt = ST_RD;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      ST_RD: begin
        rd_en     = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        wr_stat   = log_op;
        wr_rest   = log_op;
        wr_addr   = e_cur;
        // linked load address, read in the same cycle as the entry write, so it returns the old contents
        rd_en     = 1'b1;
        rd_addr   = ninfo.link_idx;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!res_valid_r || res_ready) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_stat) begin
      stat_mem[wr_addr] <= (state_r == ST_UPD) ? nstat : '0;
    end
    if (rd_en) begin
      stat_rd_r <= stat_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_rest) begin
      info_mem[wr_addr] <= (state_r == ST_UPD) ? ninfo : '0;
    end
    if (rd_en) begin
      info_rd_r <= info_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_rest) begin
      addr_mem[wr_addr] <= (state_r == ST_UPD) ? naddr : '0;
    end
    if (rd_en) begin
      addr_rd_r <= addr_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_rest) begin
      ring_mem[wr_addr] <= (state_r == ST_UPD) ? nrow : '0;
    end
    if (rd_en) begin
      ring_rd_r <= ring_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      ptr_r        <= '0;
      peak_r       <= 32'd1;
      recent_ok_r  <= 1'b0;
      recent_idx_r <= '0;
      res_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      if (state_r == ST_CLR) begin
        peak_r <= 32'd1;
      end else if (state_r == ST_UPD) begin
        peak_r <= npeak;
      end
      if (state_r == ST_UPD && log_op && cur_r.access_kind == KIND_DATA_READ) begin
        recent_ok_r  <= 1'b1;
        recent_idx_r <= e_cur;
      end
      if (res_load) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && pop_valid) begin
      cur_r <= pop_item;
    end
    if (state_r == ST_UPD) begin
      nstat_r <= nstat;
      ninfo_r <= ninfo;
      naddr_r <= naddr;
      byte_r  <= nbyte;
    end
    if (res_load) begin
      res_r.hit_count      <= nstat_r.count;
      res_r.last_cycle     <= ninfo_r.cycle;
      res_r.last_kind      <= ninfo_r.kind;
      res_r.last_requester <= ninfo_r.requester;
      res_r.full_address   <= naddr_r;
      res_r.past_value     <= byte_r;
      res_r.values_held    <= 5'(nstat_r.fill);
      res_r.load_known     <= ninfo_r.link_ok;
      // a link to the entry itself sees the address just written
      if (!ninfo_r.link_ok) begin
        res_r.load_address <= '0;
      end else if (ninfo_r.link_idx == e_cur) begin
        res_r.load_address <= naddr_r;
      end else begin
        res_r.load_address <= addr_rd_r;
      end
      res_r.peak_count <= peak_r;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

>>> design/memory_access_profiler.sv
// ----------------------------------------------------------------------------
// memory_access_profiler
// Per-address bus access profiler with hit counts, value history and
// store-to-load links.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per item; in_tuser carries the action (log, read
//           entry, clear counts), in_tdata the access fields.
//   out_* : one result per accepted transaction, in order, for the selected
//           entry as it stands after the transaction has acted.
//   cfg_* : address mask write, taken at any edge out of reset with cfg_wr_en high.
// Flow: a log or read transaction passes the front stage and the queue to the
//   table sequencer, which steps through entry read, read-modify-write with the
//   linked load lookup, and result load, and takes no new item until the result
//   of the last one is loaded. A clear transaction holds the sequencer for a
//   sweep over every entry, then reads the selected entry back for its result.
// Reset: a clearing pass zeroes every table entry; in_tready stays low
//   until it ends. Mask writes are taken meanwhile.
// Stall: a held result sits in the output register; up to four further
//   transactions are taken (one in the sequencer, a two-entry queue and the
//   front stage) before in_tready falls.
// ----------------------------------------------------------------------------
module memory_access_profiler #(
  parameter int TABLE_DEPTH = 2048,
  parameter int RING_LENGTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [10:0]                    cfg_wr_data,   // address_mask
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // cycle, address, data, access_kind, requester, back_steps
  input  logic [map_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]                     in_tuser,      // action
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // hit_count, last_cycle, last_kind, last_requester, full_address,
  // past_value, values_held, load_address, load_known, peak_count, zero pad
  output logic [map_pkg::OUT_DATA_W-1:0] out_tdata
);
  import map_pkg::*;

  logic        init_done;
  logic        push_valid;
  logic        push_ready;
  map_item_t   push_item;
  logic        pop_valid;
  logic        pop_ready;
  map_item_t   pop_item;
  map_result_t res;

  map_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .enable      (init_done),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_item   (push_item)
  );

  map_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  map_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .RING_LENGTH (RING_LENGTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .init_done (init_done),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {{(OUT_DATA_W - RES_W){1'b0}}, res};

endmodule
